// File: rtl/cfra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfra_pkg
// Shared types and constants for the continued-fraction rational
// approximation block.
// ----------------------------------------------------------------------------
package cfra_pkg;

  localparam int FRAC_BITS_DEF   = 32;
  localparam int RESULT_BITS_DEF = 32;

  localparam int VALUE_W = 64;
  localparam int NUM_W   = 32;
  localparam int DEN_W   = 31;
  localparam int TOL_W   = 20;
  localparam int PROD_W  = 128;

  localparam logic [TOL_W-1:0]   TOL_RESET = 20'd1;
  localparam logic [VALUE_W-1:0] PPM_SCALE = 64'd1000000;

  typedef enum logic [2:0] {
    MUL_AH,   // partial quotient * h1
    MUL_AK,   // partial quotient * k1
    MUL_TK,   // tolerance * k1
    MUL_TM,   // (tolerance * k1) * magnitude
    MUL_RM    // remainder * 10^6
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_MUL_H,
    S_MUL_K,
    S_CHECK,
    S_MUL_T,
    S_MUL_M,
    S_MUL_R,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic     load_in;
    logic     div_go;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     set_ovf;
    logic     advance;
    logic     next_pair;
    logic     load_out;
  } cfra_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic fit_ok;
    logic r_zero;
    logic lt;
  } cfra_sts_t;

endpackage

// File: rtl/cfra_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfra_mul
// 64 x 64 -> 128 multiplier built from one 32 x 32 multiplier, four partial
// products accumulated over successive cycles.
// ----------------------------------------------------------------------------
module cfra_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [cfra_pkg::VALUE_W-1:0] a_i,
  input  logic [cfra_pkg::VALUE_W-1:0] b_i,
  output logic                        done_o,
  output logic [cfra_pkg::PROD_W-1:0]  prod_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [2:0]                   cnt_q;
  logic                         start;
  logic [cfra_pkg::VALUE_W-1:0] a_q;
  logic [cfra_pkg::VALUE_W-1:0] b_q;
  logic [31:0]                  a_part;
  logic [31:0]                  b_part;
  logic [63:0]                  pp_d;
  logic [63:0]                  pp_q;
  logic [1:0]                   sh_q;
  logic [cfra_pkg::PROD_W-1:0]  pp_shifted;
  logic [cfra_pkg::PROD_W-1:0]  acc_q;

  assign start  = go_i && !busy_q && !done_q;
  assign a_part = cnt_q[0] ? a_q[63:32] : a_q[31:0];
  assign b_part = cnt_q[1] ? b_q[63:32] : b_q[31:0];
  assign pp_d   = a_part * b_part;

  always_comb begin
    case (sh_q)
      2'd0:    pp_shifted = {64'b0, pp_q};
      2'd1:    pp_shifted = {32'b0, pp_q, 32'b0};
      2'd2:    pp_shifted = {pp_q, 64'b0};
      default: pp_shifted = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q <= pp_d;
        sh_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + pp_shifted;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/cfra_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfra_div
// Restoring divider, one quotient bit per cycle. The first Euclid step runs
// all 64 bits; later steps have a dividend of at most 2^FRAC_BITS and run
// FRAC_BITS + 1 bits.
// ----------------------------------------------------------------------------
module cfra_div #(
  parameter int FRAC_BITS = cfra_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic                         first_i,
  input  logic [cfra_pkg::VALUE_W-1:0] dividend_i,
  input  logic [cfra_pkg::VALUE_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [cfra_pkg::VALUE_W-1:0] quo_o,
  output logic [cfra_pkg::VALUE_W-1:0] rem_o
);

  localparam int         PRE_SH  = cfra_pkg::VALUE_W - 1 - FRAC_BITS;
  localparam logic [6:0] N_FIRST = 7'(cfra_pkg::VALUE_W);
  localparam logic [6:0] N_LATER = 7'(FRAC_BITS + 1);

  logic                         busy_q;
  logic                         done_q;
  logic [6:0]                   cnt_q;
  logic                         start;
  logic [cfra_pkg::VALUE_W-1:0] dvd_q;
  logic [cfra_pkg::VALUE_W-1:0] dsr_q;
  logic [cfra_pkg::VALUE_W-1:0] rem_q;
  logic [cfra_pkg::VALUE_W-1:0] quo_q;
  logic [cfra_pkg::VALUE_W:0]   trial;
  logic [cfra_pkg::VALUE_W+1:0] diff;
  logic                         ge;

  assign start = go_i && !busy_q && !done_q;
  assign trial = {rem_q, dvd_q[cfra_pkg::VALUE_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, dsr_q};
  assign ge    = !diff[cfra_pkg::VALUE_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q <= 1'b1;
        cnt_q  <= first_i ? N_FIRST : N_LATER;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      dvd_q <= first_i ? dividend_i : (dividend_i << PRE_SH);
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[cfra_pkg::VALUE_W-2:0], 1'b0};
      rem_q <= ge ? diff[cfra_pkg::VALUE_W-1:0] : trial[cfra_pkg::VALUE_W-1:0];
      quo_q <= {quo_q[cfra_pkg::VALUE_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/cfra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfra_datapath
// Euclid pair, convergent registers, tolerance register, shared multiplier
// and divider, output register.
// ----------------------------------------------------------------------------
module cfra_datapath #(
  parameter int FRAC_BITS   = cfra_pkg::FRAC_BITS_DEF,
  parameter int RESULT_BITS = cfra_pkg::RESULT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfra_pkg::cfra_cmd_t          cmd_i,
  output cfra_pkg::cfra_sts_t          sts_o,
  input  logic                         cfg_write_i,
  input  logic [cfra_pkg::TOL_W-1:0]   cfg_data_i,
  input  logic [cfra_pkg::VALUE_W-1:0] value_i,
  output logic [cfra_pkg::NUM_W-1:0]   numerator_o,
  output logic [cfra_pkg::DEN_W-1:0]   denominator_o,
  output logic                         overflow_o
);

  localparam int          HW    = RESULT_BITS - 1;
  localparam logic [HW-1:0] LIMIT = '1;
  localparam logic [HW-1:0] ONE   = HW'(1);

  logic [cfra_pkg::TOL_W-1:0]   tol_q;
  logic [cfra_pkg::VALUE_W-1:0] mag_q;
  logic                         neg_q;
  logic [cfra_pkg::VALUE_W-1:0] p_q;
  logic [cfra_pkg::VALUE_W-1:0] q_q;
  logic [HW-1:0]                h0_q, h1_q, k0_q, k1_q;
  logic                         first_q;
  logic                         ovf_q;
  logic                         hbig_q, kbig_q;
  logic [HW-1:0]                hlow_q, klow_q;
  logic [cfra_pkg::VALUE_W-1:0] t_q;
  logic [cfra_pkg::PROD_W-1:0]  rhs_q;
  logic [cfra_pkg::NUM_W-1:0]   num_q;
  logic [cfra_pkg::DEN_W-1:0]   den_q;
  logic                         ovfo_q;

  logic [cfra_pkg::VALUE_W-1:0] mag_in;
  logic [cfra_pkg::VALUE_W-1:0] div_quo, div_rem;
  logic                         div_done;
  logic [cfra_pkg::VALUE_W-1:0] mul_a, mul_b;
  logic [cfra_pkg::PROD_W-1:0]  mul_prod;
  logic                         mul_done;
  logic [HW:0]                  hsum, ksum;
  logic [cfra_pkg::NUM_W-1:0]   h_ext;

  cfra_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (cmd_i.div_go),
    .first_i   (first_q),
    .dividend_i(p_q),
    .divisor_i (q_q),
    .done_o    (div_done),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  always_comb begin
    case (cmd_i.mul_sel)
      cfra_pkg::MUL_AH: begin
        mul_a = div_quo;
        mul_b = 64'(h1_q);
      end
      cfra_pkg::MUL_AK: begin
        mul_a = div_quo;
        mul_b = 64'(k1_q);
      end
      cfra_pkg::MUL_TK: begin
        mul_a = 64'(tol_q);
        mul_b = 64'(k1_q);
      end
      cfra_pkg::MUL_TM: begin
        mul_a = t_q;
        mul_b = mag_q;
      end
      cfra_pkg::MUL_RM: begin
        mul_a = div_rem;
        mul_b = cfra_pkg::PPM_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cfra_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (cmd_i.mul_go),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .done_o(mul_done),
    .prod_o(mul_prod)
  );

  assign mag_in = value_i[cfra_pkg::VALUE_W-1] ? (64'd0 - value_i) : value_i;
  assign hsum   = {1'b0, hlow_q} + {1'b0, h0_q};
  assign ksum   = {1'b0, klow_q} + {1'b0, k0_q};
  assign h_ext  = cfra_pkg::NUM_W'(h1_q);

  assign sts_o.div_done = div_done;
  assign sts_o.mul_done = mul_done;
  assign sts_o.fit_ok   = !hbig_q && !hsum[HW] && !kbig_q && !ksum[HW];
  assign sts_o.r_zero   = (div_rem == '0);
  assign sts_o.lt       = (mul_prod < rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= cfra_pkg::TOL_RESET;
    end else if (cfg_write_i) begin
      tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mag_q   <= mag_in;
      neg_q   <= value_i[cfra_pkg::VALUE_W-1];
      p_q     <= mag_in;
      q_q     <= 64'd1 << FRAC_BITS;
      h0_q    <= '0;
      h1_q    <= ONE;
      k0_q    <= ONE;
      k1_q    <= '0;
      first_q <= 1'b1;
      ovf_q   <= 1'b0;
    end
    if (mul_done) begin
      case (cmd_i.mul_sel)
        cfra_pkg::MUL_AH: begin
          hbig_q <= |mul_prod[cfra_pkg::PROD_W-1:HW];
          hlow_q <= mul_prod[HW-1:0];
        end
        cfra_pkg::MUL_AK: begin
          kbig_q <= |mul_prod[cfra_pkg::PROD_W-1:HW];
          klow_q <= mul_prod[HW-1:0];
        end
        cfra_pkg::MUL_TK: t_q   <= mul_prod[cfra_pkg::VALUE_W-1:0];
        cfra_pkg::MUL_TM: rhs_q <= mul_prod;
        default: ;
      endcase
    end
    if (cmd_i.set_ovf) begin
      ovf_q <= 1'b1;
      if (first_q) begin
        h1_q <= LIMIT;
        k1_q <= ONE;
      end
    end
    if (cmd_i.advance) begin
      h0_q    <= h1_q;
      h1_q    <= hsum[HW-1:0];
      k0_q    <= k1_q;
      k1_q    <= ksum[HW-1:0];
      first_q <= 1'b0;
    end
    if (cmd_i.next_pair) begin
      p_q <= q_q;
      q_q <= div_rem;
    end
    if (cmd_i.load_out) begin
      num_q  <= neg_q ? (cfra_pkg::NUM_W'(0) - h_ext) : h_ext;
      den_q  <= cfra_pkg::DEN_W'(k1_q);
      ovfo_q <= ovf_q;
    end
  end

  assign numerator_o   = num_q;
  assign denominator_o = den_q;
  assign overflow_o    = ovfo_q;

endmodule

// File: rtl/cfra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfra_ctrl
// Sequencer: one Euclid step per pass (divide, two range multiplies, range
// check, three tolerance multiplies), then the output handoff.
// ----------------------------------------------------------------------------
module cfra_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfra_pkg::cfra_cmd_t cmd_o,
  input  cfra_pkg::cfra_sts_t sts_i
);

  cfra_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfra_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.mul_sel = cfra_pkg::MUL_AH;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      cfra_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = cfra_pkg::S_DIV;
        end
      end
      cfra_pkg::S_DIV: begin
        cmd_o.div_go = 1'b1;
        if (sts_i.div_done) state_d = cfra_pkg::S_MUL_H;
      end
      cfra_pkg::S_MUL_H: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = cfra_pkg::MUL_AH;
        if (sts_i.mul_done) state_d = cfra_pkg::S_MUL_K;
      end
      cfra_pkg::S_MUL_K: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = cfra_pkg::MUL_AK;
        if (sts_i.mul_done) state_d = cfra_pkg::S_CHECK;
      end
      cfra_pkg::S_CHECK: begin
        if (!sts_i.fit_ok) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = cfra_pkg::S_FINISH;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = sts_i.r_zero ? cfra_pkg::S_FINISH : cfra_pkg::S_MUL_T;
        end
      end
      cfra_pkg::S_MUL_T: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = cfra_pkg::MUL_TK;
        if (sts_i.mul_done) state_d = cfra_pkg::S_MUL_M;
      end
      cfra_pkg::S_MUL_M: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = cfra_pkg::MUL_TM;
        if (sts_i.mul_done) state_d = cfra_pkg::S_MUL_R;
      end
      cfra_pkg::S_MUL_R: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = cfra_pkg::MUL_RM;
        if (sts_i.mul_done) begin
          if (sts_i.lt) begin
            state_d = cfra_pkg::S_FINISH;
          end else begin
            cmd_o.next_pair = 1'b1;
            state_d         = cfra_pkg::S_DIV;
          end
        end
      end
      cfra_pkg::S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = cfra_pkg::S_IDLE;
        end
      end
      default: state_d = cfra_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/continued_fraction_rational_approx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// continued_fraction_rational_approx
// Best rational approximation of a signed fixed-point value by continued
// fraction convergents, stopping at a relative error below tolerance_ppm.
//
// Input channel (in_valid_i / in_ready_o, value_i): one transaction per item.
// Output channel (out_valid_o / out_ready_i): numerator_o, denominator_o,
// overflow_o, one transaction per input item.
// Config channel (cfg_valid_i / cfg_ready_o, cfg_data_i): writes tolerance_ppm;
// always ready, write only while the block is idle.
// One item is processed at a time. Each continued-fraction term costs one
// run of the bit-serial divider (all 64 bits for the first term, FRAC_BITS + 1
// bits after) plus up to five multiplies and a range check; the result then
// passes through the output handoff. A 64-bit input needs up to about 93 terms.
// The result sits in an output register; the next input is taken while it
// waits. If the receiver stalls, a finished second result holds until the
// first is taken. Reset empties the pipe and sets tolerance_ppm to 1.
// ----------------------------------------------------------------------------
module continued_fraction_rational_approx #(
  parameter int FRAC_BITS   = cfra_pkg::FRAC_BITS_DEF,
  parameter int RESULT_BITS = cfra_pkg::RESULT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cfra_pkg::VALUE_W-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cfra_pkg::NUM_W-1:0]   numerator_o,
  output logic [cfra_pkg::DEN_W-1:0]   denominator_o,
  output logic                         overflow_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cfra_pkg::TOL_W-1:0]   cfg_data_i
);

  cfra_pkg::cfra_cmd_t cmd;
  cfra_pkg::cfra_sts_t sts;

  assign cfg_ready_o = 1'b1;

  cfra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  cfra_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .RESULT_BITS(RESULT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_write_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .value_i      (value_i),
    .numerator_o  (numerator_o),
    .denominator_o(denominator_o),
    .overflow_o   (overflow_o)
  );

endmodule
